// File: hw/rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg: shared types and codes for the compacting list table
// Operation and status codes, transfer payload structs and cell control.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int POS_W        = 6;
    localparam int STATUS_W     = 2;
    localparam int FILL_W       = 7;
    localparam int GROUP_W      = 8;   // cells per group in the first-match search
    localparam int CAPACITY_DEF = 64;

    // operation codes
    localparam logic [OP_W-1:0] OP_APPEND       = 3'd0;
    localparam logic [OP_W-1:0] OP_READ         = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_VALUE = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_AT    = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR        = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] read_value;
        logic [FILL_W-1:0]        fill_count;
    } out_item_t;

    // broadcast control shared by every cell
    typedef struct packed {
        logic              compare;
        logic [DATA_W-1:0] key;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/clt_cell.sv
// ----------------------------------------------------------------------------
// clt_cell: one entry of the list
// Holds a word, compares it against the broadcast key, and either loads a
// new word, takes its upper neighbor's word, or holds.
// ----------------------------------------------------------------------------
module clt_cell (
    input  logic                          clk,
    input  clt_pkg::cell_ctrl_t           ctrl,
    input  logic                          load_en,
    input  logic                          shift_en,
    input  logic [clt_pkg::DATA_W-1:0]    neighbor,
    output logic [clt_pkg::DATA_W-1:0]    entry,
    output logic                          match
);

    logic [clt_pkg::DATA_W-1:0] entry_reg;
    logic [clt_pkg::DATA_W-1:0] entry_next;
    logic                       match_reg;
    logic                       match_next;

    // entry update: append load wins, else shift down from neighbor
    always_comb
    begin
        entry_next = entry_reg;
        if (load_en)
        begin
            entry_next = ctrl.key;
        end
        else if (shift_en)
        begin
            entry_next = neighbor;
        end
    end

    // full bit-pattern compare, captured when requested
    always_comb
    begin
        match_next = match_reg;
        if (ctrl.compare)
        begin
            match_next = (entry_reg == ctrl.key);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

// File: hw/rtl/clt_prefix.sv
// ----------------------------------------------------------------------------
// clt_prefix: first-match search over the cell row
// Registers an in-group running OR and group flags, then combines group
// carries so that kill[i] is set at the first hit and every cell above it.
// ----------------------------------------------------------------------------
module clt_prefix #(
    parameter int N = clt_pkg::CAPACITY_DEF
) (
    input  logic         clk,
    input  logic         en,
    input  logic [N-1:0] hit,
    output logic [N-1:0] kill,
    output logic         any
);

    localparam int G  = clt_pkg::GROUP_W;
    localparam int NG = (N + G - 1) / G;

    logic [NG*G-1:0] hit_pad;
    logic [NG*G-1:0] pfx_next;
    logic [NG*G-1:0] pfx_reg;
    logic [NG-1:0]   grp_next;
    logic [NG-1:0]   grp_reg;
    logic [NG-1:0]   carry;

    assign hit_pad = (NG*G)'(hit);

    // running OR inside each group of eight
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            pfx_next[g*G] = hit_pad[g*G];
            for (int j = 1; j < G; j++)
            begin
                pfx_next[g*G+j] = pfx_next[g*G+j-1] | hit_pad[g*G+j];
            end
            grp_next[g] = pfx_next[g*G+G-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pfx_reg <= pfx_next;
            grp_reg <= grp_next;
        end
    end

    // carry from lower groups
    always_comb
    begin
        carry[0] = 1'b0;
        for (int g = 1; g < NG; g++)
        begin
            carry[g] = carry[g-1] | grp_reg[g-1];
        end
        for (int i = 0; i < N; i++)
        begin
            kill[i] = pfx_reg[i] | carry[i / G];
        end
    end

    assign any = carry[NG-1] | grp_reg[NG-1];

endmodule

// File: hw/rtl/compacting_list_table.sv
// ----------------------------------------------------------------------------
// compacting_list_table: bounded packed list of 32-bit words
// Top level: sequencer, fill count, cell row and result register.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid / in_stall / in_data carry one operation (append, read,
//   remove by value, remove at position, clear). A transfer happens on a
//   rising edge with valid high and stall low. Every operation yields one
//   result on out_valid / out_stall / out_data: status, read word, count.
//   Each item passes compare, first-match search and apply in turn; the
//   apply step posts the result and waits on a stalled output. One item
//   is in flight at a time: a new item waits until the last is applied,
//   behind the registered compare and two-step search across the cell row.
//   The result register parts the two channels: the next item is accepted
//   while a result waits, and only the apply step waits on a stalled output.
//   Removal shifts every cell above the gap down by one at the same time.
//   Reset (rst_n low, asynchronous) empties the list and drops any pending
//   result. Stored words are not cleared; only cells below the count ever
//   count as hits or are returned by a read.
// ----------------------------------------------------------------------------
module compacting_list_table #(
    parameter int CAPACITY = clt_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  clt_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output clt_pkg::out_item_t  out_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = (CW > clt_pkg::POS_W) ? CW : clt_pkg::POS_W;
    localparam int DW = clt_pkg::DATA_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_PFX   = 2'd2;
    localparam logic [1:0] S_APPLY = 2'd3;

    logic [1:0]                     state_reg, state_next;
    logic [clt_pkg::OP_W-1:0]       op_reg, op_next;
    logic [DW-1:0]                  val_reg, val_next;
    logic [clt_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [DW-1:0]                  rd_reg, rd_next;
    logic                           out_valid_reg, out_valid_next;
    clt_pkg::out_item_t             out_reg, out_next;

    clt_pkg::cell_ctrl_t            ctrl;
    logic [DW-1:0]                  entry [CAPACITY];
    logic [CAPACITY-1:0]            match;
    logic [CAPACITY-1:0]            hit;
    logic [CAPACITY-1:0]            kill;
    logic [CAPACITY-1:0]            at_kill;
    logic [CAPACITY-1:0]            load_en;
    logic [CAPACITY-1:0]            shift_en;
    logic                           any;

    logic                           in_fire;
    logic                           out_fire;
    logic                           apply_go;
    logic [PW-1:0]                  pos_ext;
    logic [PW-1:0]                  cnt_ext;
    logic                           pos_ok;
    logic                           full;
    logic                           do_append;
    logic                           do_shift_value;
    logic                           do_shift_at;

    assign in_fire  = in_valid & ~in_stall;
    assign out_fire = out_valid_reg & ~out_stall;
    assign apply_go = (state_reg == S_APPLY) & (~out_valid_reg | ~out_stall);

    assign pos_ext = PW'(pos_reg);
    assign cnt_ext = PW'(count_reg);
    assign pos_ok  = pos_ext < cnt_ext;
    assign full    = count_reg >= CW'(CAPACITY);

    assign do_append      = apply_go & (op_reg == clt_pkg::OP_APPEND) & ~full;
    assign do_shift_value = apply_go & (op_reg == clt_pkg::OP_REMOVE_VALUE) & any;
    assign do_shift_at    = apply_go & (op_reg == clt_pkg::OP_REMOVE_AT) & pos_ok;

    // broadcast to the cells: key doubles as the append word
    assign ctrl.compare = (state_reg == S_CMP);
    assign ctrl.key     = val_reg;

    // cell row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DW-1:0] upper;
        if (i < CAPACITY - 1)
        begin : g_mid
            assign upper = entry[i+1];
        end
        else
        begin : g_top
            assign upper = entry[i];
        end

        assign hit[i]      = match[i] & (PW'(i) < cnt_ext);
        assign at_kill[i]  = PW'(i) >= pos_ext;
        assign load_en[i]  = do_append & (count_reg == CW'(i));
        assign shift_en[i] = (do_shift_value & kill[i]) | (do_shift_at & at_kill[i]);

        clt_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .load_en  (load_en[i]),
            .shift_en (shift_en[i]),
            .neighbor (upper),
            .entry    (entry[i]),
            .match    (match[i])
        );
    end

    clt_prefix #(
        .N (CAPACITY)
    ) u_prefix (
        .clk  (clk),
        .en   (state_reg == S_PFX),
        .hit  (hit),
        .kill (kill),
        .any  (any)
    );

    // sequencer and apply step
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        rd_next        = rd_reg;
        out_valid_next = out_valid_reg & ~out_fire;
        out_next       = out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next    = in_data.operation;
                    val_next   = in_data.value;
                    pos_next   = in_data.position;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                rd_next = '0;
                if (pos_ext < PW'(CAPACITY))
                begin
                    rd_next = entry[pos_ext[IW-1:0]];
                end
                state_next = S_PFX;
            end
            S_PFX:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (apply_go)
                begin
                    out_next.status     = clt_pkg::ST_OK;
                    out_next.read_value = '0;
                    case (op_reg)
                        clt_pkg::OP_APPEND:
                        begin
                            if (full)
                            begin
                                out_next.status = clt_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        clt_pkg::OP_READ:
                        begin
                            if (pos_ok)
                            begin
                                out_next.read_value = rd_reg;
                            end
                            else
                            begin
                                out_next.status = clt_pkg::ST_RANGE;
                            end
                        end
                        clt_pkg::OP_REMOVE_VALUE:
                        begin
                            if (any)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                out_next.status = clt_pkg::ST_NOT_FOUND;
                            end
                        end
                        clt_pkg::OP_REMOVE_AT:
                        begin
                            if (pos_ok)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                out_next.status = clt_pkg::ST_RANGE;
                            end
                        end
                        clt_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    out_next.fill_count = clt_pkg::FILL_W'(count_next);
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        val_reg <= val_next;
        pos_reg <= pos_next;
        rd_reg  <= rd_next;
        out_reg <= out_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_CMP))
        else $error("accepted transfer did not start compare");

    a_apply_result: assert property (@(posedge clk) disable iff (!rst_n)
        apply_go |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("apply step did not post a result");

    a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (do_shift_value || do_shift_at) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("removal did not decrement the count");

    a_single_owner: assert property (@(posedge clk) disable iff (!rst_n)
        do_append |-> $onehot(load_en))
        else $error("append loaded other than one cell");

endmodule
